// ----- hdl/l4hx_pkg.sv -----
// Types and constants shared by the IPv4 L4 header extractor.
// No dependencies.
package l4hx_pkg;

	localparam int unsigned OFF_W = 11;
	localparam logic [OFF_W-1:0] OFFSET_SAT = '1;

	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;
	localparam logic [7:0] PROTO_ICMP = 8'd1;

	// Min bytes each kind needs past L4 start, NEED_IP past L2.
	localparam logic [OFF_W-1:0] NEED_TCP  = 11'd13;
	localparam logic [OFF_W-1:0] NEED_UDP  = 11'd4;
	localparam logic [OFF_W-1:0] NEED_ICMP = 11'd2;
	localparam logic [OFF_W-1:0] NEED_IP   = 11'd20;

	typedef enum logic [1:0] {
		KIND_OTHER = 2'd0,
		KIND_TCP   = 2'd1,
		KIND_UDP   = 2'd2,
		KIND_ICMP  = 2'd3
	} kind_t;

	// Record handed from the front to the back through the queue.
	typedef struct packed {
		kind_t       kind;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] port_a;
		logic [15:0] port_b;
		logic [31:0] seq;
		logic [3:0]  data_off;
		logic        short_frame;
	} rec_t;

	localparam int unsigned REC_W = $bits(rec_t);

endpackage

// ----- hdl/l4hx_front.sv -----
// Front part: counts byte offsets, captures header fields, classifies
// the frame and emits one record on the last byte. Depends on l4hx_pkg.
module l4hx_front import l4hx_pkg::*; #(
	parameter int L2_HEADER_BYTES = 14,
	parameter int MAX_FRAME_BYTES = 1518
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       rec_push,
	output rec_t       rec
);

	localparam logic [OFF_W-1:0] L2   = OFF_W'(L2_HEADER_BYTES);
	localparam logic [OFF_W-1:0] MAXB = OFF_W'(MAX_FRAME_BYTES);

	logic [OFF_W-1:0] off_q, seen_q;
	logic [3:0]       ihl_q, doff_q;
	logic [7:0]       proto_q;
	logic [31:0]      src_q, dst_q, seq_q;
	logic [15:0]      pa_q, pb_q;

	logic [OFF_W-1:0] off_nxt, seen_nxt, r, l4, q, need_l4, need;
	logic [3:0]       ihl_nxt, doff_nxt;
	logic [7:0]       proto_nxt;
	logic [31:0]      src_nxt, dst_nxt, seq_nxt;
	logic [15:0]      pa_nxt, pb_nxt;
	logic             in_win, hdr_hit, l4_hit;
	kind_t            kind;

	always_comb begin
		in_win    = off_q < MAXB;
		hdr_hit   = in_win && (off_q >= L2);
		r         = off_q - L2;
		ihl_nxt   = ihl_q;
		proto_nxt = proto_q;
		src_nxt   = src_q;
		dst_nxt   = dst_q;
		if (hdr_hit) begin
			if (r == 11'd0)
				ihl_nxt = data_byte[3:0];
			else if (r == 11'd9)
				proto_nxt = data_byte;
			else if (r >= 11'd12 && r <= 11'd15)
				src_nxt = {src_q[23:0], data_byte};
			else if (r >= 11'd16 && r <= 11'd19)
				dst_nxt = {dst_q[23:0], data_byte};
		end

		// L4 start follows the header length captured in this same cycle.
		l4       = L2 + {5'd0, ihl_nxt, 2'b00};
		l4_hit   = in_win && (off_q >= l4);
		q        = off_q - l4;
		pa_nxt   = pa_q;
		pb_nxt   = pb_q;
		seq_nxt  = seq_q;
		doff_nxt = doff_q;
		if (l4_hit) begin
			if (q <= 11'd1)
				pa_nxt = {pa_q[7:0], data_byte};
			else if (q <= 11'd3)
				pb_nxt = {pb_q[7:0], data_byte};
			else if (q <= 11'd7)
				seq_nxt = {seq_q[23:0], data_byte};
			else if (q == 11'd12)
				doff_nxt = data_byte[7:4];
		end

		seen_nxt = in_win ? off_q + 11'd1 : seen_q;
		off_nxt  = (off_q == OFFSET_SAT) ? off_q : off_q + 11'd1;

		unique case (proto_nxt)
			PROTO_TCP:  kind = KIND_TCP;
			PROTO_UDP:  kind = KIND_UDP;
			PROTO_ICMP: kind = KIND_ICMP;
			default:    kind = KIND_OTHER;
		endcase

		unique case (kind)
			KIND_TCP:  need_l4 = l4 + NEED_TCP;
			KIND_UDP:  need_l4 = l4 + NEED_UDP;
			KIND_ICMP: need_l4 = l4 + NEED_ICMP;
			default:   need_l4 = '0;
		endcase
		need = (need_l4 > L2 + NEED_IP) ? need_l4 : L2 + NEED_IP;

		rec_push         = take && last_byte;
		rec.kind         = kind;
		rec.src_addr     = src_nxt;
		rec.dst_addr     = dst_nxt;
		rec.port_a       = pa_nxt;
		rec.port_b       = pb_nxt;
		rec.seq          = seq_nxt;
		rec.data_off     = doff_nxt;
		rec.short_frame  = seen_nxt < need;
	end

	// Advance per byte; clear all frame state after the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q   <= '0;
			seen_q  <= '0;
			ihl_q   <= '0;
			proto_q <= '0;
			src_q   <= '0;
			dst_q   <= '0;
			pa_q    <= '0;
			pb_q    <= '0;
			seq_q   <= '0;
			doff_q  <= '0;
		end else if (take) begin
			if (last_byte) begin
				off_q   <= '0;
				seen_q  <= '0;
				ihl_q   <= '0;
				proto_q <= '0;
				src_q   <= '0;
				dst_q   <= '0;
				pa_q    <= '0;
				pb_q    <= '0;
				seq_q   <= '0;
				doff_q  <= '0;
			end else begin
				off_q   <= off_nxt;
				seen_q  <= seen_nxt;
				ihl_q   <= ihl_nxt;
				proto_q <= proto_nxt;
				src_q   <= src_nxt;
				dst_q   <= dst_nxt;
				pa_q    <= pa_nxt;
				pb_q    <= pb_nxt;
				seq_q   <= seq_nxt;
				doff_q  <= doff_nxt;
			end
		end
	end

endmodule

// ----- hdl/l4hx_fifo.sv -----
// Two-entry record queue between front and back.
// Depends on l4hx_pkg.
module l4hx_fifo import l4hx_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  rec_t wr_data,
	output logic full,
	input  logic rd_en,
	output logic nonempty,
	output rec_t rd_data
);

	rec_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign full     = cnt_q == 2'd2;
	assign nonempty = cnt_q != 2'd0;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= ~wr_ptr_q;
			if (rd_en)
				rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end

endmodule

// ----- hdl/l4hx_back.sv -----
// Back part: takes records from the queue, zeroes the fields that the
// kind does not report and holds the result in an output register. Uses l4hx_pkg.
module l4hx_back import l4hx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rec_avail,
	input  rec_t        rec,
	output logic        rec_take,
	input  logic        pop,
	output logic        empty,
	output logic [1:0]  proto_kind,
	output logic [31:0] src_addr,
	output logic [31:0] dst_addr,
	output logic [15:0] source_port,
	output logic [15:0] dest_port,
	output logic [31:0] seq_number,
	output logic [5:0]  tcp_hdr_bytes,
	output logic [7:0]  icmp_kind,
	output logic [7:0]  icmp_subcode,
	output logic        short_frame
);

	logic valid_q, has_ports, is_tcp, is_icmp;

	assign rec_take  = rec_avail && (!valid_q || pop);
	assign empty     = !valid_q;
	assign is_tcp    = rec.kind == KIND_TCP;
	assign is_icmp   = rec.kind == KIND_ICMP;
	assign has_ports = is_tcp || rec.kind == KIND_UDP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (rec_take)
			valid_q <= 1'b1;
		else if (pop)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (rec_take) begin
			proto_kind    <= rec.kind;
			src_addr      <= rec.src_addr;
			dst_addr      <= rec.dst_addr;
			source_port   <= has_ports ? rec.port_a : 16'd0;
			dest_port     <= has_ports ? rec.port_b : 16'd0;
			seq_number    <= is_tcp ? rec.seq : 32'd0;
			tcp_hdr_bytes <= is_tcp ? {rec.data_off, 2'b00} : 6'd0;
			icmp_kind     <= is_icmp ? rec.port_a[15:8] : 8'd0;
			icmp_subcode  <= is_icmp ? rec.port_a[7:0] : 8'd0;
			short_frame   <= rec.short_frame;
		end
	end

endmodule

// ----- hdl/ipv4_l4_header_extractor.sv -----
// Top level of the IPv4 L4 header extractor: front, record queue, back.
// Depends on l4hx_pkg, l4hx_front, l4hx_fifo and l4hx_back.
//
// Usage:
//   Input channel (push/full): one Ethernet frame byte per item, in wire
//   order, with last_byte marking the final byte. A byte is taken on an
//   edge where push is high and full is low.
//   Result channel (empty/pop): one record per frame, shown while empty is
//   low and taken on an edge where pop is high.
// Throughput: one byte per cycle while full is low, also across frames.
// Record path: the edge that takes a frame's last byte writes its record
//   into the two-entry queue; the output register loads it from there
//   once that register is empty or being popped.
// Stalls: while pop is held low the output register holds its record and
//   the queue absorbs up to two more; full rises only once both are taken,
//   so bytes keep flowing until three frames are waiting.
// Reset: arst_n clears the offset counter, all captured fields, the queue
//   and the output valid; the block takes bytes once it is released.
// Fields that the frame never delivered read as zero and short_frame is set.
module ipv4_l4_header_extractor import l4hx_pkg::*; #(
	parameter int L2_HEADER_BYTES = 14,
	parameter int MAX_FRAME_BYTES = 1518
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  proto_kind,
	output logic [31:0] src_addr,
	output logic [31:0] dst_addr,
	output logic [15:0] source_port,
	output logic [15:0] dest_port,
	output logic [31:0] seq_number,
	output logic [5:0]  tcp_hdr_bytes,
	output logic [7:0]  icmp_kind,
	output logic [7:0]  icmp_subcode,
	output logic        short_frame
);

	logic take, rec_push, rec_avail, rec_take;
	rec_t rec_in, rec_out;

	// Accept a byte whenever the queue has room for a possible record.
	assign take = push && !full;

	l4hx_front #(
		.L2_HEADER_BYTES(L2_HEADER_BYTES),
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.rec_push  (rec_push),
		.rec       (rec_in)
	);

	l4hx_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (rec_push),
		.wr_data  (rec_in),
		.full     (full),
		.rd_en    (rec_take),
		.nonempty (rec_avail),
		.rd_data  (rec_out)
	);

	l4hx_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.rec_avail     (rec_avail),
		.rec           (rec_out),
		.rec_take      (rec_take),
		.pop           (pop),
		.empty         (empty),
		.proto_kind    (proto_kind),
		.src_addr      (src_addr),
		.dst_addr      (dst_addr),
		.source_port   (source_port),
		.dest_port     (dest_port),
		.seq_number    (seq_number),
		.tcp_hdr_bytes (tcp_hdr_bytes),
		.icmp_kind     (icmp_kind),
		.icmp_subcode  (icmp_subcode),
		.short_frame   (short_frame)
	);

endmodule

// ----- hdl/l4hx_checker.sv -----
// Port-level checks on the IPv4 L4 header extractor, bound to its top level.
// Depends on l4hx_pkg.
module l4hx_checker import l4hx_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [1:0]  proto_kind,
	input logic [31:0] src_addr,
	input logic [15:0] source_port,
	input logic [15:0] dest_port,
	input logic [31:0] seq_number,
	input logic [5:0]  tcp_hdr_bytes,
	input logic [7:0]  icmp_kind,
	input logic [7:0]  icmp_subcode
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(src_addr) && $stable(proto_kind))
		else $error("result changed while stalled");

	a_tcp_only: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && proto_kind != KIND_TCP |-> seq_number == 32'd0 && tcp_hdr_bytes == 6'd0)
		else $error("tcp fields set on non-tcp record");

	a_ports: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (proto_kind == KIND_OTHER || proto_kind == KIND_ICMP)
		|-> source_port == 16'd0 && dest_port == 16'd0)
		else $error("ports set on record without ports");

	a_icmp_only: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && proto_kind != KIND_ICMP |-> icmp_kind == 8'd0 && icmp_subcode == 8'd0)
		else $error("icmp fields set on non-icmp record");

	a_hdr_align: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> tcp_hdr_bytes[1:0] == 2'b00)
		else $error("tcp header length not a multiple of four");

endmodule

bind ipv4_l4_header_extractor l4hx_checker u_l4hx_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.empty         (empty),
	.pop           (pop),
	.proto_kind    (proto_kind),
	.src_addr      (src_addr),
	.source_port   (source_port),
	.dest_port     (dest_port),
	.seq_number    (seq_number),
	.tcp_hdr_bytes (tcp_hdr_bytes),
	.icmp_kind     (icmp_kind),
	.icmp_subcode  (icmp_subcode)
);

// ----- verif/l4hx_record_check.sv -----
// Record check for the IPv4 L4 header extractor: predicts one record per frame
// from the accepted bytes and compares it with every popped record.
// Depends on l4hx_pkg.
module l4hx_record_check import l4hx_pkg::*; #(
	parameter int L2_HEADER_BYTES = 14,
	parameter int MAX_FRAME_BYTES = 1518
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        empty,
	input  logic        pop,
	input  logic [1:0]  proto_kind,
	input  logic [31:0] src_addr,
	input  logic [31:0] dst_addr,
	input  logic [15:0] source_port,
	input  logic [15:0] dest_port,
	input  logic [31:0] seq_number,
	input  logic [5:0]  tcp_hdr_bytes,
	input  logic [7:0]  icmp_kind,
	input  logic [7:0]  icmp_subcode,
	input  logic        short_frame,
	output int          mismatches,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		kind_t       kind;
		logic [31:0] src;
		logic [31:0] dst;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [31:0] seq;
		logic [5:0]  hdr_bytes;
		logic [7:0]  itype;
		logic [7:0]  icode;
		logic        truncated;
	} frame_record_t;

	frame_record_t expected_records[$];

	// Per-frame capture state.
	logic [OFF_W-1:0] offset    = '0;
	logic [OFF_W-1:0] seen      = '0;
	logic [3:0]       ihl       = '0;
	logic [7:0]       proto     = '0;
	logic [31:0]      sa        = '0;
	logic [31:0]      da        = '0;
	logic [15:0]      pa        = '0;
	logic [15:0]      pb        = '0;
	logic [31:0]      sq        = '0;
	logic [3:0]       doff      = '0;

	initial begin
		mismatches  = 0;
		outstanding = 0;
	end

	task automatic clear_frame();
		offset = '0;
		seen   = '0;
		ihl    = '0;
		proto  = '0;
		sa     = '0;
		da     = '0;
		pa     = '0;
		pb     = '0;
		sq     = '0;
		doff   = '0;
	endtask

	task automatic absorb_byte(input logic [7:0] b, input logic fin);
		int unsigned   off;
		int unsigned   r;
		int unsigned   l4;
		int unsigned   q;
		int unsigned   need;
		frame_record_t rec;
		off = offset;
		if (off < MAX_FRAME_BYTES) begin
			if (off >= L2_HEADER_BYTES) begin
				r = off - L2_HEADER_BYTES;
				if (r == 0)
					ihl = b[3:0];
				else if (r == 9)
					proto = b;
				else if (r >= 12 && r <= 15)
					sa = {sa[23:0], b};
				else if (r >= 16 && r <= 19)
					da = {da[23:0], b};
			end
			// L4 start uses the header length as updated by this very byte.
			l4 = L2_HEADER_BYTES + 4 * ihl;
			if (off >= l4) begin
				q = off - l4;
				if (q <= 1)
					pa = {pa[7:0], b};
				else if (q <= 3)
					pb = {pb[7:0], b};
				else if (q <= 7)
					sq = {sq[23:0], b};
				else if (q == 12)
					doff = b[7:4];
			end
			seen = OFF_W'(off + 1);
		end
		offset = (offset < OFFSET_SAT) ? offset + 1'b1 : OFFSET_SAT;

		if (fin) begin
			l4 = L2_HEADER_BYTES + 4 * ihl;
			case (proto)
				PROTO_TCP:  rec.kind = KIND_TCP;
				PROTO_UDP:  rec.kind = KIND_UDP;
				PROTO_ICMP: rec.kind = KIND_ICMP;
				default:    rec.kind = KIND_OTHER;
			endcase
			need = L2_HEADER_BYTES + NEED_IP;
			if (rec.kind == KIND_TCP && l4 + NEED_TCP > need)
				need = l4 + NEED_TCP;
			if (rec.kind == KIND_UDP && l4 + NEED_UDP > need)
				need = l4 + NEED_UDP;
			if (rec.kind == KIND_ICMP && l4 + NEED_ICMP > need)
				need = l4 + NEED_ICMP;
			rec.src       = sa;
			rec.dst       = da;
			rec.sport     = (rec.kind == KIND_TCP || rec.kind == KIND_UDP) ? pa : '0;
			rec.dport     = (rec.kind == KIND_TCP || rec.kind == KIND_UDP) ? pb : '0;
			rec.seq       = (rec.kind == KIND_TCP) ? sq : '0;
			rec.hdr_bytes = (rec.kind == KIND_TCP) ? {doff, 2'b00} : '0;
			rec.itype     = (rec.kind == KIND_ICMP) ? pa[15:8] : '0;
			rec.icode     = (rec.kind == KIND_ICMP) ? pa[7:0] : '0;
			rec.truncated = (seen < need);
			expected_records.push_back(rec);
			clear_frame();
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
		end
	endtask

	task automatic compare_record();
		frame_record_t want;
		if (expected_records.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: record with no frame behind it: kind %0d src %h dst %h",
					$realtime, proto_kind, src_addr, dst_addr);
		end else begin
			want = expected_records.pop_front();
			check_field("proto_kind", 32'(want.kind), 32'(proto_kind));
			check_field("src_addr", want.src, src_addr);
			check_field("dst_addr", want.dst, dst_addr);
			check_field("source_port", 32'(want.sport), 32'(source_port));
			check_field("dest_port", 32'(want.dport), 32'(dest_port));
			check_field("seq_number", want.seq, seq_number);
			check_field("tcp_hdr_bytes", 32'(want.hdr_bytes), 32'(tcp_hdr_bytes));
			check_field("icmp_kind", 32'(want.itype), 32'(icmp_kind));
			check_field("icmp_subcode", 32'(want.icode), 32'(icmp_subcode));
			check_field("short_frame", 32'(want.truncated), 32'(short_frame));
		end
	endtask

	// Bytes are taken before records are compared, so a same-edge record
	// always finds its expectation already queued.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_frame();
			expected_records.delete();
			outstanding = 0;
		end else begin
			if (push && !full)
				absorb_byte(data_byte, last_byte);
			if (pop && !empty)
				compare_record();
			outstanding = expected_records.size();
		end
	end

endmodule

// ----- verif/tb_ipv4_l4_header_extractor.sv -----
// Testbench top for the IPv4 L4 header extractor: clock, reset, frame
// stimulus, receiver pacing and the verdict.
// Depends on l4hx_pkg, ipv4_l4_header_extractor and l4hx_record_check.
module tb_ipv4_l4_header_extractor import l4hx_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int L2_BYTES     = 14;
	localparam int MAX_BYTES    = 1518;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;
	// Far beyond the slowest correct run.
	localparam int RUN_LIMIT_NS = 10_000_000;

	typedef enum {FILL_ZERO, FILL_ONES, FILL_RANDOM} fill_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        push      = 1'b0;
	logic [7:0]  data_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        pop       = 1'b0;
	logic        full;
	logic        empty;
	logic [1:0]  proto_kind;
	logic [31:0] src_addr;
	logic [31:0] dst_addr;
	logic [15:0] source_port;
	logic [15:0] dest_port;
	logic [31:0] seq_number;
	logic [5:0]  tcp_hdr_bytes;
	logic [7:0]  icmp_kind;
	logic [7:0]  icmp_subcode;
	logic        short_frame;

	int mismatch_count;
	int records_due;

	// Pacing knobs, in percent of cycles.
	int send_idle  = 0;
	int recv_stall = 0;
	// Set by the sender, cleared by the receiver once its hold-off is over.
	bit hold_req   = 1'b0;

	logic [7:0] frame_bytes[$];
	int         bytes_sent;

	ipv4_l4_header_extractor #(
		.L2_HEADER_BYTES(L2_BYTES),
		.MAX_FRAME_BYTES(MAX_BYTES)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.empty        (empty),
		.pop          (pop),
		.proto_kind   (proto_kind),
		.src_addr     (src_addr),
		.dst_addr     (dst_addr),
		.source_port  (source_port),
		.dest_port    (dest_port),
		.seq_number   (seq_number),
		.tcp_hdr_bytes(tcp_hdr_bytes),
		.icmp_kind    (icmp_kind),
		.icmp_subcode (icmp_subcode),
		.short_frame  (short_frame)
	);

	l4hx_record_check #(
		.L2_HEADER_BYTES(L2_BYTES),
		.MAX_FRAME_BYTES(MAX_BYTES)
	) record_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.empty        (empty),
		.pop          (pop),
		.proto_kind   (proto_kind),
		.src_addr     (src_addr),
		.dst_addr     (dst_addr),
		.source_port  (source_port),
		.dest_port    (dest_port),
		.seq_number   (seq_number),
		.tcp_hdr_bytes(tcp_hdr_bytes),
		.icmp_kind    (icmp_kind),
		.icmp_subcode (icmp_subcode),
		.short_frame  (short_frame),
		.mismatches   (mismatch_count),
		.outstanding  (records_due)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Safety net: end the run if the handshakes ever stop moving.
	initial begin
		#(RUN_LIMIT_NS);
		$display("simulation failed");
		$finish;
	end

	// Receiver: pop at the rate the current phase allows. On request, hold
	// pop low for a long, counted stretch so the block backs up into full.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	// Bytes a frame must carry so the record is complete for its protocol.
	function automatic int frame_need(input logic [7:0] proto, input logic [3:0] ihl);
		int l4;
		int need;
		l4 = L2_BYTES + 4 * ihl;
		need = L2_BYTES + 20;
		if (proto == PROTO_TCP && l4 + 13 > need)
			need = l4 + 13;
		if (proto == PROTO_UDP && l4 + 4 > need)
			need = l4 + 4;
		if (proto == PROTO_ICMP && l4 + 2 > need)
			need = l4 + 2;
		return need;
	endfunction

	// Build a frame of len bytes, then plant the header length nibble and the
	// protocol byte where they fall inside the frame.
	task automatic build_frame(input logic [7:0] proto, input logic [3:0] ihl,
			input int len, input fill_t fill);
		logic [7:0] b;
		frame_bytes.delete();
		for (int i = 0; i < len; i++) begin
			case (fill)
				FILL_ZERO: begin
					b = 8'h00;
				end
				FILL_ONES: begin
					b = 8'hFF;
				end
				default: begin
					b = 8'($urandom);
				end
			endcase
			frame_bytes.push_back(b);
		end
		if (len > L2_BYTES)
			frame_bytes[L2_BYTES] = (frame_bytes[L2_BYTES] & 8'hF0) | {4'h0, ihl};
		if (len > L2_BYTES + 9)
			frame_bytes[L2_BYTES + 9] = proto;
	endtask

	// TCP/UDP/ICMP frames with random content, each field mostly well-formed;
	// the rest are other protocols, odd header lengths and frames cut short.
	task automatic build_random_frame();
		logic [7:0] proto;
		logic [3:0] ihl;
		int         sel;
		int         need;
		int         len;
		sel = $urandom_range(99);
		if (sel < 30)
			proto = PROTO_TCP;
		else if (sel < 55)
			proto = PROTO_UDP;
		else if (sel < 75)
			proto = PROTO_ICMP;
		else
			proto = 8'($urandom);
		sel = $urandom_range(99);
		if (sel < 70)
			ihl = 4'd5;
		else if (sel < 85)
			ihl = 4'($urandom_range(6, 15));
		else
			ihl = 4'($urandom_range(0, 4));
		need = frame_need(proto, ihl);
		sel = $urandom_range(99);
		if (sel < 70)
			len = need + $urandom_range(0, 24);
		else if (sel < 90)
			len = $urandom_range(1, need - 1);
		else
			len = $urandom_range(1, 14);
		build_frame(proto, ihl, len, FILL_RANDOM);
	endtask

	// Offer one byte and hold it until the block takes it. Random idle
	// cycles go in front of it per the sender's idle rate.
	task automatic send_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push      <= 1'b1;
		data_byte <= b;
		last_byte <= fin;
		do
			@(posedge clk);
		while (full);
	endtask

	task automatic send_frame();
		foreach (frame_bytes[i])
			send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
		bytes_sent += frame_bytes.size();
	endtask

	// Stop offering and wait until every expected record has been popped.
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (records_due != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int phase_bytes;
		int phase_frames;

		// Hold reset, then release it on an edge.
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames, no idling.
		bytes_sent = 0;
		send_idle  = 0;
		recv_stall = 0;
		// Single-byte frame: protocol never seen.
		build_frame(PROTO_TCP, 4'd5, 1, FILL_ONES);
		send_frame();
		// TCP exactly long enough, all ones; then one byte short.
		build_frame(PROTO_TCP, 4'd5, 47, FILL_ONES);
		send_frame();
		build_frame(PROTO_TCP, 4'd5, 46, FILL_ONES);
		send_frame();
		// UDP exact and one short.
		build_frame(PROTO_UDP, 4'd5, 38, FILL_ZERO);
		send_frame();
		build_frame(PROTO_UDP, 4'd5, 37, FILL_RANDOM);
		send_frame();
		// ICMP exact and one short.
		build_frame(PROTO_ICMP, 4'd5, 36, FILL_RANDOM);
		send_frame();
		build_frame(PROTO_ICMP, 4'd5, 35, FILL_ZERO);
		send_frame();
		// Other protocols: addresses only; the second ends inside the
		// destination address.
		build_frame(8'hFF, 4'd5, 34, FILL_ONES);
		send_frame();
		build_frame(8'h00, 4'd5, 33, FILL_RANDOM);
		send_frame();
		// Header length below five: L4 fields come from inside the IP header.
		build_frame(PROTO_TCP, 4'd0, 40, FILL_RANDOM);
		send_frame();
		build_frame(PROTO_UDP, 4'd4, 30, FILL_RANDOM);
		send_frame();
		// Largest header length.
		build_frame(PROTO_TCP, 4'd15, 87, FILL_ZERO);
		send_frame();
		build_frame(PROTO_ICMP, 4'd15, 76, FILL_ONES);
		send_frame();
		drain();

		// Random frames over four pacing phases.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle  = 0;
					recv_stall = 0;
				end
				1: begin
					send_idle  = 80;
					recv_stall = 0;
				end
				2: begin
					send_idle  = 0;
					recv_stall = 80;
				end
				default: begin
					send_idle  = 28;
					recv_stall = 28;
				end
			endcase
			phase_bytes  = 0;
			phase_frames = 0;
			while (phase_bytes < 250 || phase_frames < 7) begin
				bytes_sent = 0;
				build_random_frame();
				send_frame();
				phase_bytes += bytes_sent;
				phase_frames++;
				// Long receiver hold-off while frames keep coming.
				if (phase == 0 && phase_frames == 4) begin
					hold_req = 1'b1;
					while (hold_req) begin
						build_random_frame();
						send_frame();
						phase_bytes += bytes_sent;
						phase_frames++;
					end
				end
				// Sender pause until every record is out.
				if (phase == 2 && phase_frames == 6)
					drain();
			end
			drain();
		end

		if (mismatch_count == 0 && records_due == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ----- ipv4_l4_header_extractor.f -----
hdl/l4hx_pkg.sv
hdl/l4hx_front.sv
hdl/l4hx_fifo.sv
hdl/l4hx_back.sv
hdl/ipv4_l4_header_extractor.sv
hdl/l4hx_checker.sv
verif/l4hx_record_check.sv
verif/tb_ipv4_l4_header_extractor.sv
